[sv/ktbg_pkg.sv]
// shared types, constants and table functions for the keyed tone burst generator
package ktbg_pkg;

    localparam int SINE_TABLE_BITS_DEF    = 10;
    localparam int ENV_TABLE_BITS_DEF     = 8;
    localparam int SEG_COUNT_BITS_DEF     = 16;
    localparam int CMD_DEPTH              = 4;
    localparam int OUT_DEPTH              = 8;

    localparam logic [7:0]  KEY_DOWN_BYTE = 8'h5E;
    localparam logic [7:0]  KEY_UP_BYTE   = 8'h5F;
    localparam logic        OP_BYTE       = 1'b0;
    localparam logic        OP_TICK       = 1'b1;
    localparam logic        KIND_SAMPLE   = 1'b0;
    localparam logic        KIND_ECHO     = 1'b1;
    localparam logic [16:0] ENV_ONE       = 17'h10000;
    localparam logic [29:0] HALF_Q30      = 30'h2000_0000;
    localparam logic [14:0] AMPLITUDE     = 15'd32500;

    localparam logic [63:0] ONE_Q30 = 64'd1073741824;
    localparam logic [63:0] C1      = 64'd1686629713;
    localparam logic [63:0] C3      = 64'd693598668;
    localparam logic [63:0] C5      = 64'd85569306;
    localparam logic [63:0] C7      = 64'd5026995;
    localparam logic [63:0] C9      = 64'd172273;
    localparam logic [63:0] C11     = 64'd3855;

    typedef enum logic [1:0] {
        WAVE_OFF    = 2'd0,
        WAVE_SINE   = 2'd1,
        WAVE_SAW    = 2'd2,
        WAVE_SQUARE = 2'd3
    } t_wave;

    typedef enum logic [2:0] {
        CFG_PHASE_STEP  = 3'd0,
        CFG_WAVE_SELECT = 3'd1,
        CFG_EDGE_LEN    = 3'd2,
        CFG_EDGE_STEP   = 3'd3,
        CFG_TONE_LEN    = 3'd4,
        CFG_GAP_LEN     = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic       op;
        logic [7:0] key_byte;
    } t_in_item;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] sample;
        logic [7:0]         echo_byte;
        logic               segment_first;
    } t_out_item;

    typedef struct packed {
        logic [31:0] phase_step;
        t_wave       wave_select;
        logic [11:0] edge_len;
        logic [15:0] edge_step;
        logic [15:0] tone_len;
        logic [15:0] gap_len;
    } t_cfg;

    typedef struct packed {
        logic        kind;
        logic [7:0]  echo_byte;
        logic        first;
        t_wave       wave;
        logic [31:0] tone_phase;
        logic        rise_en;
        logic [16:0] rise_phase;
        logic        fall_en;
        logic [16:0] fall_phase;
    } t_cmd;

    // sin(pi/2 * u), u and result in q30
    function automatic logic [30:0] f_quarter_sin(input logic [63:0] u);
        logic [63:0] u2;
        logic [63:0] p;
        u2 = (u * u) >> 30;
        p  = C11;
        p  = C9 - ((u2 * p) >> 30);
        p  = C7 - ((u2 * p) >> 30);
        p  = C5 - ((u2 * p) >> 30);
        p  = C3 - ((u2 * p) >> 30);
        p  = C1 - ((u2 * p) >> 30);
        p  = (u * p) >> 30;
        if (p > ONE_Q30) begin
            p = ONE_Q30;
        end
        return p[30:0];
    endfunction

    // quarter wave sine magnitude, entry k of a table of 2^(sb-2)+1 entries
    function automatic logic [30:0] f_sine_entry(input int k, input int sb);
        return f_quarter_sin((64'(k) << 30) >> (sb - 2));
    endfunction

    // sine squared envelope in q16
    function automatic logic [16:0] f_env_entry(input int k, input int eb);
        logic [63:0] s;
        logic [63:0] e;
        s = 64'(f_quarter_sin((64'(k) << 30) >> eb));
        e = (s * s) >> 44;
        if (e > 64'(ENV_ONE)) begin
            e = 64'(ENV_ONE);
        end
        return e[16:0];
    endfunction

endpackage

[sv/keyed_tone_burst_generator_unit.sv]
// top level: configuration registers, front end, command queue, back end, result queue
// an input transfer passes through the command queue and the back end stages s1, s2, s3 into the result queue
// throughput: one item per cycle unless a queue fills, set by the front end and the 3-stage back end
// the command queue (4 deep) and result queue (8 deep) let each side stall on its own
// reset: synchronous active low; clears queues, key latch and sequencer, loads register defaults
module keyed_tone_burst_generator_unit
    import ktbg_pkg::*;
#(
    parameter int SINE_TABLE_BITS     = SINE_TABLE_BITS_DEF,
    parameter int ENVELOPE_TABLE_BITS = ENV_TABLE_BITS_DEF,
    parameter int SEGMENT_COUNT_BITS  = SEG_COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_in_item    i_item,
    output logic        empty,
    input  logic        pop,
    output t_out_item   o_result,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int OUT_CNT_W = $clog2(OUT_DEPTH) + 1;
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH) + 1;

    t_cfg                 r_cfg;
    logic                 w_accept;
    logic                 w_cmd_push;
    t_cmd                 w_cmd_in;
    t_cmd                 w_cmd_out;
    logic                 w_cmd_empty;
    logic                 w_cmd_pop;
    logic [CMD_CNT_W-1:0] w_cmd_count;
    logic                 w_res_push;
    t_out_item            w_res;
    logic                 w_res_full;
    logic [OUT_CNT_W-1:0] w_res_count;

    assign w_accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_step  <= 32'd77913240;
            r_cfg.wave_select <= WAVE_SINE;
            r_cfg.edge_len    <= 12'd88;
            r_cfg.edge_step   <= 16'd745;
            r_cfg.tone_len    <= 16'd2293;
            r_cfg.gap_len     <= 16'd2117;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PHASE_STEP:  r_cfg.phase_step  <= i_cfg_data;
                CFG_WAVE_SELECT: r_cfg.wave_select <= t_wave'(i_cfg_data[1:0]);
                CFG_EDGE_LEN:    r_cfg.edge_len    <= i_cfg_data[11:0];
                CFG_EDGE_STEP:   r_cfg.edge_step   <= i_cfg_data[15:0];
                CFG_TONE_LEN:    r_cfg.tone_len    <= i_cfg_data[15:0];
                CFG_GAP_LEN:     r_cfg.gap_len     <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    ktbg_front #(
        .SEG_BITS (SEGMENT_COUNT_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_item     (i_item),
        .i_cfg      (r_cfg),
        .o_cmd_push (w_cmd_push),
        .o_cmd      (w_cmd_in)
    );

    ktbg_fifo #(
        .DEPTH (CMD_DEPTH),
        .T     (t_cmd)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_cmd_in),
        .o_full  (full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_out),
        .o_empty (w_cmd_empty),
        .o_count (w_cmd_count)
    );

    ktbg_back #(
        .SINE_BITS   (SINE_TABLE_BITS),
        .ENV_BITS    (ENVELOPE_TABLE_BITS),
        .OUT_DEPTH_P (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!w_cmd_empty && (w_cmd_count != '0)),
        .i_cmd       (w_cmd_out),
        .o_cmd_pop   (w_cmd_pop),
        .i_out_count (w_res_count),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    ktbg_fifo #(
        .DEPTH (OUT_DEPTH),
        .T     (t_out_item)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop && !w_res_full ? pop : pop),
        .o_data  (o_result),
        .o_empty (empty),
        .o_count (w_res_count)
    );

endmodule

[sv/ktbg_fifo.sv]
// small first-word-fall-through queue
module ktbg_fifo
    import ktbg_pkg::*;
#(
    parameter int  DEPTH = CMD_DEPTH,
    parameter type T     = t_cmd
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  T                         i_data,
    output logic                     o_full,
    input  logic                     i_pop,
    output T                         o_data,
    output logic                     o_empty,
    output logic [$clog2(DEPTH):0]   o_count
);

    localparam int PTR_W = $clog2(DEPTH);

    T                 r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[sv/ktbg_front.sv]
// front end: key latch, segment sequencer and phase accumulators
module ktbg_front
    import ktbg_pkg::*;
#(
    parameter int SEG_BITS = SEG_COUNT_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    input  t_cfg     i_cfg,
    output logic     o_cmd_push,
    output t_cmd     o_cmd
);

    localparam int CMP_W = ((SEG_BITS > 16) ? SEG_BITS : 16) + 2;

    logic                r_key_down;
    logic                r_in_tone;
    logic                r_seg_active;
    logic [SEG_BITS-1:0] r_index;
    logic [31:0]         r_tone_phase;
    logic [16:0]         r_rise_phase;
    logic [16:0]         r_fall_phase;

    logic                w_tick;
    logic                w_key_byte;
    logic                w_tone;
    logic [SEG_BITS-1:0] w_x;
    logic [31:0]         w_tp;
    logic [16:0]         w_rp;
    logic [16:0]         w_fp;
    logic [16:0]         w_fp_new;
    logic [15:0]         w_len;
    logic [CMP_W-1:0]    w_x_ext;
    logic                w_rise_en;
    logic                w_fall_en;
    logic                w_last;

    function automatic logic [16:0] f_sat_add(input logic [16:0] p, input logic [15:0] s);
        logic [17:0] sum;
        sum = 18'(p) + 18'(s);
        return (sum > 18'(ENV_ONE)) ? ENV_ONE : sum[16:0];
    endfunction

    assign w_tick     = (i_item.op == OP_TICK);
    assign w_key_byte = (i_item.key_byte == KEY_DOWN_BYTE) || (i_item.key_byte == KEY_UP_BYTE);
    assign w_tone     = r_seg_active ? r_in_tone : r_key_down;
    assign w_x        = r_seg_active ? r_index : '0;
    assign w_tp       = r_seg_active ? r_tone_phase : '0;
    assign w_rp       = r_seg_active ? r_rise_phase : '0;
    assign w_fp       = r_seg_active ? r_fall_phase : '0;
    assign w_fp_new   = f_sat_add(w_fp, i_cfg.edge_step);
    assign w_len      = w_tone ? i_cfg.tone_len : i_cfg.gap_len;
    assign w_x_ext    = CMP_W'(w_x);
    assign w_rise_en  = w_x_ext < CMP_W'(i_cfg.edge_len);
    assign w_fall_en  = (w_x_ext + CMP_W'(i_cfg.edge_len)) > CMP_W'(w_len);
    assign w_last     = ((w_x_ext + CMP_W'(2)) >= CMP_W'(w_len))
                     || ((w_x_ext + CMP_W'(1)) >= CMP_W'({SEG_BITS{1'b1}}));

    assign o_cmd_push = i_accept && (w_tick || !w_key_byte);

    always_comb begin
        o_cmd            = '0;
        o_cmd.kind       = w_tick ? KIND_SAMPLE : KIND_ECHO;
        o_cmd.wave       = WAVE_OFF;
        if (w_tick) begin
            o_cmd.first      = !r_seg_active;
            o_cmd.wave       = w_tone ? i_cfg.wave_select : WAVE_OFF;
            o_cmd.tone_phase = w_tp;
            o_cmd.rise_en    = w_rise_en;
            o_cmd.rise_phase = w_rp;
            o_cmd.fall_en    = w_fall_en;
            o_cmd.fall_phase = w_fp_new;
        end else begin
            o_cmd.echo_byte  = i_item.key_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_down   <= 1'b0;
            r_in_tone    <= 1'b0;
            r_seg_active <= 1'b0;
            r_index      <= '0;
            r_tone_phase <= '0;
            r_rise_phase <= '0;
            r_fall_phase <= '0;
        end else if (i_accept) begin
            if (!w_tick) begin
                if (i_item.key_byte == KEY_DOWN_BYTE) begin
                    r_key_down <= 1'b1;
                end else if (i_item.key_byte == KEY_UP_BYTE) begin
                    r_key_down <= 1'b0;
                end
            end else begin
                r_in_tone    <= w_tone;
                r_tone_phase <= w_tp + i_cfg.phase_step;
                r_rise_phase <= w_rise_en ? f_sat_add(w_rp, i_cfg.edge_step) : w_rp;
                r_fall_phase <= w_fall_en ? w_fp_new : w_fp;
                r_seg_active <= !w_last;
                r_index      <= w_last ? w_x : w_x + 1'b1;
            end
        end
    end

endmodule

[sv/ktbg_back.sv]
// back end: waveform and envelope lookups, envelope and amplitude multiplies
module ktbg_back
    import ktbg_pkg::*;
#(
    parameter int SINE_BITS   = SINE_TABLE_BITS_DEF,
    parameter int ENV_BITS    = ENV_TABLE_BITS_DEF,
    parameter int OUT_DEPTH_P = OUT_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cmd_valid,
    input  t_cmd                         i_cmd,
    output logic                         o_cmd_pop,
    input  logic [$clog2(OUT_DEPTH_P):0] i_out_count,
    output logic                         o_res_push,
    output t_out_item                    o_res
);

    localparam int SINE_Q = 1 << (SINE_BITS - 2);
    localparam int ENV_N  = 1 << ENV_BITS;
    localparam int CNT_W  = $clog2(OUT_DEPTH_P) + 1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  echo_byte;
        logic        first;
        t_wave       wave;
        logic [30:0] sine_mag;
        logic        sine_neg;
        logic [29:0] alt_mag;
        logic        alt_neg;
        logic        rise_en;
        logic [16:0] env_r;
        logic        fall_en;
        logic [16:0] env_f;
    } t_s1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  echo_byte;
        logic        first;
        logic        neg;
        logic [30:0] mag;
        logic        fall_en;
        logic [16:0] env_f;
    } t_s2;

    typedef struct packed {
        logic        kind;
        logic [7:0]  echo_byte;
        logic        first;
        logic        neg;
        logic [30:0] mag;
    } t_s3;

    logic [30:0] w_sine_rom [SINE_Q+1];
    logic [16:0] w_env_rom  [ENV_N+1];

    for (genvar g = 0; g <= SINE_Q; g++) begin : g_sine
        assign w_sine_rom[g] = f_sine_entry(g, SINE_BITS);
    end
    for (genvar g = 0; g <= ENV_N; g++) begin : g_env
        assign w_env_rom[g] = f_env_entry(g, ENV_BITS);
    end

    logic                 r_v1;
    logic                 r_v2;
    logic                 r_v3;
    t_s1                  r_s1;
    t_s2                  r_s2;
    t_s3                  r_s3;

    logic [SINE_BITS-1:0] w_sine_pos;
    logic [SINE_BITS-2:0] w_sine_off;
    logic [SINE_BITS-2:0] w_sine_idx;
    logic [ENV_BITS:0]    w_rise_idx;
    logic [ENV_BITS:0]    w_fall_idx;
    logic [29:0]          w_alt_mag;
    logic                 w_alt_neg;
    logic [CNT_W:0]       w_used;
    logic [30:0]          w_mag2;
    logic                 w_neg2;
    logic [47:0]          w_prod_r;
    logic [47:0]          w_prod_f;
    logic [45:0]          w_prod_a;
    logic [15:0]          w_s;

    assign w_sine_pos = i_cmd.tone_phase[31 -: SINE_BITS];
    assign w_sine_off = {1'b0, w_sine_pos[SINE_BITS-3:0]};
    assign w_sine_idx = w_sine_pos[SINE_BITS-2]
                      ? (SINE_BITS-1)'(SINE_Q) - w_sine_off : w_sine_off;
    assign w_rise_idx = i_cmd.rise_phase[16 -: (ENV_BITS+1)];
    assign w_fall_idx = (ENV_BITS+1)'(ENV_N) - i_cmd.fall_phase[16 -: (ENV_BITS+1)];

    always_comb begin
        w_alt_mag = '0;
        w_alt_neg = 1'b0;
        case (i_cmd.wave)
            WAVE_SAW: begin
                if (i_cmd.tone_phase[31]) begin
                    w_alt_mag = {1'b0, i_cmd.tone_phase[30:2]};
                end else begin
                    w_alt_mag = HALF_Q30 - {1'b0, i_cmd.tone_phase[30:2]};
                    w_alt_neg = 1'b1;
                end
            end
            WAVE_SQUARE: begin
                w_alt_mag = HALF_Q30;
                w_alt_neg = !((i_cmd.tone_phase != '0) && !i_cmd.tone_phase[31]);
            end
            default: begin
                w_alt_mag = '0;
                w_alt_neg = 1'b0;
            end
        endcase
    end

    // room in the output queue for everything already in flight
    assign w_used    = (CNT_W+1)'(i_out_count) + (CNT_W+1)'(r_v1)
                     + (CNT_W+1)'(r_v2) + (CNT_W+1)'(r_v3);
    assign o_cmd_pop = i_cmd_valid && (w_used < (CNT_W+1)'(OUT_DEPTH_P));

    assign w_mag2   = (r_s1.wave == WAVE_SINE) ? r_s1.sine_mag : {1'b0, r_s1.alt_mag};
    assign w_neg2   = (r_s1.wave == WAVE_SINE) ? r_s1.sine_neg : r_s1.alt_neg;
    assign w_prod_r = 48'(w_mag2) * 48'(r_s1.env_r);
    assign w_prod_f = 48'(r_s2.mag) * 48'(r_s2.env_f);
    assign w_prod_a = 46'(r_s3.mag) * 46'(AMPLITUDE);
    assign w_s      = 16'(w_prod_a >> 30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= o_cmd_pop;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1.kind      <= i_cmd.kind;
        r_s1.echo_byte <= i_cmd.echo_byte;
        r_s1.first     <= i_cmd.first;
        r_s1.wave      <= i_cmd.wave;
        r_s1.sine_mag  <= w_sine_rom[w_sine_idx];
        r_s1.sine_neg  <= w_sine_pos[SINE_BITS-1];
        r_s1.alt_mag   <= w_alt_mag;
        r_s1.alt_neg   <= w_alt_neg;
        r_s1.rise_en   <= i_cmd.rise_en;
        r_s1.env_r     <= w_env_rom[w_rise_idx];
        r_s1.fall_en   <= i_cmd.fall_en;
        r_s1.env_f     <= w_env_rom[w_fall_idx];

        r_s2.kind      <= r_s1.kind;
        r_s2.echo_byte <= r_s1.echo_byte;
        r_s2.first     <= r_s1.first;
        r_s2.neg       <= w_neg2;
        r_s2.mag       <= r_s1.rise_en ? 31'(w_prod_r >> 16) : w_mag2;
        r_s2.fall_en   <= r_s1.fall_en;
        r_s2.env_f     <= r_s1.env_f;

        r_s3.kind      <= r_s2.kind;
        r_s3.echo_byte <= r_s2.echo_byte;
        r_s3.first     <= r_s2.first;
        r_s3.neg       <= r_s2.neg;
        r_s3.mag       <= r_s2.fall_en ? 31'(w_prod_f >> 16) : r_s2.mag;
    end

    assign o_res_push          = r_v3;
    assign o_res.kind          = r_s3.kind;
    assign o_res.sample        = r_s3.neg ? -w_s : w_s;
    assign o_res.echo_byte     = r_s3.echo_byte;
    assign o_res.segment_first = r_s3.first;

endmodule

[bench/tb_keyed_tone_burst_generator_unit.sv]
// self-checking bench for the keyed tone burst generator: directed table, random phases, bit-exact predictor
`timescale 1ns / 1ps

module tb_keyed_tone_burst_generator_unit;
    import ktbg_pkg::*;

    localparam int          SINE_BITS     = SINE_TABLE_BITS_DEF;
    localparam int          ENV_BITS      = ENV_TABLE_BITS_DEF;
    localparam int          SINE_SIZE     = 1 << SINE_BITS;
    localparam int          SINE_QUARTER  = SINE_SIZE / 4;
    localparam int          ENV_SIZE      = 1 << ENV_BITS;
    localparam int unsigned SEG_MAX       = (1 << SEG_COUNT_BITS_DEF) - 1;
    localparam int unsigned ENV_FULL      = 65536;
    localparam logic [63:0] Q30_ONE       = 64'd1073741824;
    localparam longint      HALF_WAVE     = 64'sd536870912;
    localparam logic [63:0] TAYLOR_1      = 64'd1686629713;
    localparam logic [63:0] TAYLOR_3      = 64'd693598668;
    localparam logic [63:0] TAYLOR_5      = 64'd85569306;
    localparam logic [63:0] TAYLOR_7      = 64'd5026995;
    localparam logic [63:0] TAYLOR_9      = 64'd172273;
    localparam logic [63:0] TAYLOR_11     = 64'd3855;
    localparam int          IDLE_PCT      = 38;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          TAIL_CYCLES   = 20;
    localparam int          RAND_PHASES   = 10;
    localparam int          PHASE_ITEMS   = 170;
    localparam int          LONG_TICKS    = 300;
    localparam int          CYCLE_LIMIT   = 1000000;

    typedef struct packed {
        bit        typed;
        t_out_item want;
    } t_note;

    typedef struct packed {
        bit          is_write;
        t_cfg_idx    reg_idx;
        logic [31:0] reg_val;
        t_in_item    item;
        bit          typed;
        t_out_item   want;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    t_in_item    i_item;
    logic        empty;
    logic        pop;
    t_out_item   o_result;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    bit          tx_idle;
    bit          rx_idle;
    int          errors;
    int          cycles;
    t_note       note_q [$];
    t_out_item   pending_results [$];
    t_dir_row    plan [$];

    // predictor configuration and state
    logic [31:0] r_phase_step;
    t_wave       r_wave;
    logic [11:0] r_edge_len;
    logic [15:0] r_edge_step;
    logic [15:0] r_tone_len;
    logic [15:0] r_gap_len;
    bit          key_held;
    bit          tone_seg;
    bit          seg_on;
    int unsigned seg_pos;
    logic [31:0] acc_phase;
    int unsigned up_phase;
    int unsigned down_phase;
    int          sine_lut [SINE_SIZE];
    int unsigned env_lut [ENV_SIZE + 1];

    keyed_tone_burst_generator_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // sin(pi/2 * u) in q30, odd polynomial by horner steps
    function automatic logic [63:0] quarter_wave(input logic [63:0] u);
        logic [63:0] u2;
        logic [63:0] acc;
        u2  = (u * u) >> 30;
        acc = TAYLOR_11;
        acc = TAYLOR_9 - ((u2 * acc) >> 30);
        acc = TAYLOR_7 - ((u2 * acc) >> 30);
        acc = TAYLOR_5 - ((u2 * acc) >> 30);
        acc = TAYLOR_3 - ((u2 * acc) >> 30);
        acc = TAYLOR_1 - ((u2 * acc) >> 30);
        acc = (u * acc) >> 30;
        return (acc > Q30_ONE) ? Q30_ONE : acc;
    endfunction

    function automatic int unsigned env_slot(input int unsigned p);
        return ((p > ENV_FULL) ? ENV_FULL : p) >> (16 - ENV_BITS);
    endfunction

    function automatic int unsigned env_sat(input int unsigned p, input int unsigned step);
        int unsigned s;
        s = p + step;
        return (s > ENV_FULL) ? ENV_FULL : s;
    endfunction

    task automatic reset_model();
        int          quad;
        logic [63:0] u;
        logic [63:0] v;
        for (int i = 0; i < SINE_SIZE; i++) begin
            quad = i / SINE_QUARTER;
            u    = (64'(i % SINE_QUARTER) << 30) >> (SINE_BITS - 2);
            if (quad % 2 == 1) begin
                u = Q30_ONE - u;
            end
            v = quarter_wave(u);
            sine_lut[i] = (quad >= 2) ? -int'(v) : int'(v);
        end
        for (int i = 0; i <= ENV_SIZE; i++) begin
            u = quarter_wave((64'(i) << 30) >> ENV_BITS);
            v = (u * u) >> 44;
            env_lut[i] = (v > 64'(ENV_FULL)) ? ENV_FULL : int'(v);
        end
        r_phase_step = 32'd77913240;
        r_wave       = WAVE_SINE;
        r_edge_len   = 12'd88;
        r_edge_step  = 16'd745;
        r_tone_len   = 16'd2293;
        r_gap_len    = 16'd2117;
        key_held     = 1'b0;
        tone_seg     = 1'b0;
        seg_on       = 1'b0;
        seg_pos      = 0;
        acc_phase    = '0;
        up_phase     = 0;
        down_phase   = 0;
    endtask

    // one input transfer through the burst generator, at most one output
    task automatic burst_model_step(input t_in_item it, output bit has, output t_out_item res);
        int unsigned span;
        int unsigned x;
        longint      wave;
        logic [63:0] mag;
        logic [31:0] s;
        bit          first;
        has = 1'b0;
        res = '0;
        if (it.op == OP_BYTE) begin
            if (it.key_byte == KEY_DOWN_BYTE) begin
                key_held = 1'b1;
            end else if (it.key_byte == KEY_UP_BYTE) begin
                key_held = 1'b0;
            end else begin
                has           = 1'b1;
                res.kind      = KIND_ECHO;
                res.echo_byte = it.key_byte;
            end
        end else begin
            first = 1'b0;
            if (!seg_on) begin
                seg_on     = 1'b1;
                tone_seg   = key_held;
                seg_pos    = 0;
                acc_phase  = '0;
                up_phase   = 0;
                down_phase = 0;
                first      = 1'b1;
            end
            span = tone_seg ? {16'b0, r_tone_len} : {16'b0, r_gap_len};
            x    = seg_pos;
            wave = 0;
            if (tone_seg) begin
                case (r_wave)
                    WAVE_SINE: begin
                        wave = sine_lut[acc_phase >> (32 - SINE_BITS)];
                    end
                    WAVE_SAW: begin
                        wave = $signed({32'b0, acc_phase >> 2}) - HALF_WAVE;
                    end
                    WAVE_SQUARE: begin
                        wave = (acc_phase != 0 && !acc_phase[31]) ? HALF_WAVE : -HALF_WAVE;
                    end
                    default: begin
                        wave = 0;
                    end
                endcase
            end
            acc_phase = acc_phase + r_phase_step;
            mag = (wave < 0) ? 64'(-wave) : 64'(wave);
            if (x < {20'b0, r_edge_len}) begin
                mag      = (mag * env_lut[env_slot(up_phase)]) >> 16;
                up_phase = env_sat(up_phase, {16'b0, r_edge_step});
            end
            if (x + {20'b0, r_edge_len} > span) begin
                down_phase = env_sat(down_phase, {16'b0, r_edge_step});
                mag        = (mag * env_lut[ENV_SIZE - env_slot(down_phase)]) >> 16;
            end
            s = 32'((mag * 64'(AMPLITUDE)) >> 30);
            if (x + 2 >= span || x + 1 >= SEG_MAX) begin
                seg_on = 1'b0;
            end else begin
                seg_pos = (x + 1) & SEG_MAX;
            end
            has               = 1'b1;
            res.kind          = KIND_SAMPLE;
            res.sample        = (wave < 0) ? 16'(32'd0 - s) : s[15:0];
            res.segment_first = first;
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t %s mismatch: expected %0h actual %0h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_watch
        bit        has;
        t_out_item pred;
        t_out_item want;
        t_note     nt;
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_PHASE_STEP:  r_phase_step = i_cfg_data;
                    CFG_WAVE_SELECT: r_wave       = t_wave'(i_cfg_data[1:0]);
                    CFG_EDGE_LEN:    r_edge_len   = i_cfg_data[11:0];
                    CFG_EDGE_STEP:   r_edge_step  = i_cfg_data[15:0];
                    CFG_TONE_LEN:    r_tone_len   = i_cfg_data[15:0];
                    CFG_GAP_LEN:     r_gap_len    = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (push && !full) begin
                nt = (note_q.size() != 0) ? note_q.pop_front() : '0;
                burst_model_step(i_item, has, pred);
                if (has) begin
                    pending_results.push_back(nt.typed ? nt.want : pred);
                end
            end
            if (pop && !empty) begin
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t unexpected result: expected none actual %p",
                             $time, o_result);
                end else begin
                    want = pending_results.pop_front();
                    check_field("kind", want.kind, o_result.kind);
                    check_field("sample", 32'(want.sample), 32'(o_result.sample));
                    check_field("echo_byte", want.echo_byte, o_result.echo_byte);
                    check_field("segment_first", want.segment_first, o_result.segment_first);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        pop <= i_rst_n && (!rx_idle || $urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic send_item(input t_in_item it, input bit typed, input t_out_item want);
        note_q.push_back('{typed, want});
        @(negedge i_clk);
        while (tx_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_results.size() != 0 || note_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic write_all(input logic [31:0] ps, input t_wave wv, input logic [11:0] el,
                             input logic [15:0] es, input logic [15:0] tl,
                             input logic [15:0] gl);
        wait_idle();
        write_reg(CFG_PHASE_STEP, ps);
        write_reg(CFG_WAVE_SELECT, 32'(wv));
        write_reg(CFG_EDGE_LEN, 32'(el));
        write_reg(CFG_EDGE_STEP, 32'(es));
        write_reg(CFG_TONE_LEN, 32'(tl));
        write_reg(CFG_GAP_LEN, 32'(gl));
    endtask

    function automatic t_out_item as_sample(input logic signed [15:0] v, input logic first);
        t_out_item r;
        r               = '0;
        r.kind          = KIND_SAMPLE;
        r.sample        = v;
        r.segment_first = first;
        return r;
    endfunction

    function automatic t_out_item as_echo(input logic [7:0] b);
        t_out_item r;
        r           = '0;
        r.kind      = KIND_ECHO;
        r.echo_byte = b;
        return r;
    endfunction

    function automatic t_dir_row row_wr(input t_cfg_idx idx, input logic [31:0] val);
        t_dir_row r;
        r          = '0;
        r.is_write = 1'b1;
        r.reg_idx  = idx;
        r.reg_val  = val;
        return r;
    endfunction

    function automatic t_dir_row row_item(input logic op, input logic [7:0] b);
        t_dir_row r;
        r      = '0;
        r.item = {op, b};
        return r;
    endfunction

    function automatic t_dir_row row_known(input logic op, input logic [7:0] b,
                                           input t_out_item want);
        t_dir_row r;
        r       = row_item(op, b);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic t_in_item random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 78) begin
            return {OP_TICK, 8'($urandom)};
        end else if (r < 90) begin
            return {OP_BYTE, ($urandom_range(0, 1) != 0) ? KEY_DOWN_BYTE : KEY_UP_BYTE};
        end
        return {OP_BYTE, 8'($urandom)};
    endfunction

    initial begin
        logic [11:0] el;
        push        = 1'b0;
        pop         = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        tx_idle     = 1'b1;
        rx_idle     = 1'b1;
        errors      = 0;
        cycles      = 0;

        // directed table, starting from the reset register values
        plan.push_back(row_known(OP_TICK, 8'h00, as_sample(16'sd0, 1'b1)));
        plan.push_back(row_known(OP_BYTE, 8'h00, as_echo(8'h00)));
        plan.push_back(row_known(OP_BYTE, 8'hFF, as_echo(8'hFF)));
        plan.push_back(row_known(OP_BYTE, 8'h5D, as_echo(8'h5D)));
        plan.push_back(row_known(OP_BYTE, 8'h60, as_echo(8'h60)));
        plan.push_back(row_item(OP_BYTE, KEY_DOWN_BYTE));
        plan.push_back(row_known(OP_TICK, 8'hFF, as_sample(16'sd0, 1'b0)));
        plan.push_back(row_wr(CFG_GAP_LEN, 32'd2));
        plan.push_back(row_known(OP_TICK, 8'h00, as_sample(16'sd0, 1'b0)));
        plan.push_back(row_known(OP_TICK, 8'h00, as_sample(16'sd0, 1'b1)));
        plan.push_back(row_wr(CFG_WAVE_SELECT, 32'(WAVE_SQUARE)));
        plan.push_back(row_item(OP_TICK, 8'hA5));
        plan.push_back(row_wr(CFG_EDGE_LEN, 32'd0));
        plan.push_back(row_wr(CFG_PHASE_STEP, 32'hFFFF_FFFF));
        plan.push_back(row_item(OP_TICK, 8'h5A));
        plan.push_back(row_item(OP_TICK, 8'h00));
        plan.push_back(row_wr(CFG_WAVE_SELECT, 32'(WAVE_SAW)));
        plan.push_back(row_item(OP_TICK, 8'h00));
        plan.push_back(row_wr(CFG_EDGE_LEN, 32'd4095));
        plan.push_back(row_wr(CFG_EDGE_STEP, 32'd0));
        plan.push_back(row_item(OP_TICK, 8'h00));
        plan.push_back(row_wr(CFG_TONE_LEN, 32'd0));
        plan.push_back(row_item(OP_TICK, 8'h00));
        plan.push_back(row_item(OP_BYTE, KEY_UP_BYTE));
        plan.push_back(row_known(OP_TICK, 8'h00, as_sample(16'sd0, 1'b1)));
        plan.push_back(row_known(OP_TICK, 8'h00, as_sample(16'sd0, 1'b1)));
        plan.push_back(row_wr(CFG_GAP_LEN, 32'd1));
        plan.push_back(row_known(OP_TICK, 8'h00, as_sample(16'sd0, 1'b1)));
        plan.push_back(row_wr(CFG_EDGE_LEN, 32'd1));
        plan.push_back(row_wr(CFG_EDGE_STEP, 32'hFFFF));
        plan.push_back(row_wr(CFG_PHASE_STEP, 32'd0));
        plan.push_back(row_wr(CFG_WAVE_SELECT, 32'(WAVE_SINE)));
        plan.push_back(row_wr(CFG_TONE_LEN, 32'd1));
        plan.push_back(row_item(OP_BYTE, KEY_DOWN_BYTE));
        plan.push_back(row_known(OP_TICK, 8'h00, as_sample(16'sd0, 1'b1)));
        plan.push_back(row_wr(CFG_WAVE_SELECT, 32'(WAVE_OFF)));
        plan.push_back(row_known(OP_TICK, 8'h00, as_sample(16'sd0, 1'b1)));
        plan.push_back(row_wr(CFG_WAVE_SELECT, 32'(WAVE_SQUARE)));
        plan.push_back(row_wr(CFG_TONE_LEN, 32'hFFFF));
        plan.push_back(row_item(OP_TICK, 8'h00));
        plan.push_back(row_item(OP_TICK, 8'hFF));
        plan.push_back(row_item(OP_TICK, 8'h00));

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_write) begin
                wait_idle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                send_item(plan[i].item, plan[i].typed, plan[i].want);
            end
        end

        // random phases, short segments mostly, extremes in the first two
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == 0) begin
                write_all(32'd0, t_wave'(ph % 4), 12'd1, 16'd1, 16'd2, 16'd2);
            end else if (ph == 1) begin
                write_all(32'hFFFF_FFFF, t_wave'(ph % 4), 12'd4095, 16'hFFFF, 16'd3, 16'd40);
            end else begin
                el = 12'($urandom_range(1, 24));
                write_all($urandom, t_wave'(ph % 4), el,
                          ($urandom_range(0, 1) != 0) ? 16'(65536 / el)
                                                      : 16'($urandom_range(1, 65535)),
                          16'($urandom_range(2, 48)), 16'($urandom_range(2, 48)));
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_item(random_item(), 1'b0, '0);
            end
        end

        // one long tone segment with both sides streaming
        write_all($urandom, WAVE_SINE, 12'd4095, 16'd16, 16'hFFFF, 16'd2);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_item({OP_BYTE, KEY_DOWN_BYTE}, 1'b0, '0);
        for (int n = 0; n < LONG_TICKS; n++) begin
            send_item({OP_TICK, 8'($urandom)}, 1'b0, '0);
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
